// ===== src/mm4_pkg.sv =====
// mm4_pkg: item structs and microcode ROM for the 4x4 fixed-point matrix multiplier.
// Depends on nothing; used by src/matrix4_multiply.sv.
package mm4_pkg;

    // one input transfer: element write, optional multiply afterwards
    typedef struct packed {
        logic               operation;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic               compute_after;
    } t_in_item;

    // one output transfer: product element
    typedef struct packed {
        logic [3:0]         result_index;
        logic signed [31:0] result_value;
        logic               result_last;
    } t_out_item;

    localparam int UC_AW = 2;
    typedef logic [UC_AW-1:0] t_uc_addr;

    localparam t_uc_addr UC_IDLE = 2'd0;
    localparam t_uc_addr UC_MAC  = 2'd1;
    localparam t_uc_addr UC_MACL = 2'd2;

    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_K_PEN  = 2'd1,
        COND_E_LAST = 2'd2
    } t_uc_cond;

    typedef struct packed {
        logic     issue;     // issue one operand pair read
        logic     last_k;    // tag: last term of the dot product
        logic     elem_adv;  // step to the next product element
        t_uc_cond cond;
        t_uc_addr taken;     // next step when cond holds
        t_uc_addr other;     // next step otherwise
    } t_uc_word;

    function automatic t_uc_word uc_rom(input t_uc_addr addr);
        t_uc_word w;
        w.issue    = 1'b0;
        w.last_k   = 1'b0;
        w.elem_adv = 1'b0;
        w.cond     = COND_ALWAYS;
        w.taken    = UC_IDLE;
        w.other    = UC_IDLE;
        case (addr)
            UC_MAC: begin
                w.issue = 1'b1;
                w.cond  = COND_K_PEN;
                w.taken = UC_MACL;
                w.other = UC_MAC;
            end
            UC_MACL: begin
                w.issue    = 1'b1;
                w.last_k   = 1'b1;
                w.elem_adv = 1'b1;
                w.cond     = COND_E_LAST;
                w.taken    = UC_IDLE;
                w.other    = UC_MAC;
            end
            default: begin
                w.cond  = COND_ALWAYS;
                w.taken = UC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/matrix4_multiply.sv =====
// matrix4_multiply: DIM x DIM signed fixed-point matrix product, microcoded sequencer.
// Depends on src/mm4_pkg.sv (item structs, microcode ROM).
//
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ------------------------------------
// in        sink       i_in_valid / o_in_stall t_in_item: store one operand element
// out       source     o_out_valid/i_out_stall t_out_item: one product element
//
// Flow: an element write is one transfer per cycle while the sequencer is idle. A
// transfer with compute_after runs the microprogram, DIM^3 operand-pair reads (64 at
// DIM=4) from the two element memories, one a cycle unless an output stall freezes
// the sequencer; input is stalled until the microprogram is back at idle. Each
// product goes through the operand, product, accumulator and output registers.
// Reset (synchronous, active low) clears the sequencer and pipe valids; the element
// memories hold nothing meaningful until written.
// An output stall with a result waiting freezes the sequencer and the whole pipe.
module matrix4_multiply #(
    parameter int DIM        = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mm4_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mm4_pkg::t_out_item o_out
);
    import mm4_pkg::*;

    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int KW     = $clog2(DIM);
    localparam int FRAC   = DATA_WIDTH / 2;
    // sum of DIM full products
    localparam int ACC_W  = 2 * DATA_WIDTH + $clog2(DIM);

    // ---------------------------------------------------------------
    // Input transfer and element write
    // ---------------------------------------------------------------
    logic              in_xfer;
    logic [7:0]        idx_wide;
    logic [ADDR_W-1:0] wr_addr;
    logic              idx_ok;
    logic              wr_left;
    logic              wr_right;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign idx_wide = {4'd0, i_in.element_index};
    assign wr_addr  = idx_wide[ADDR_W-1:0];
    assign idx_ok   = idx_wide < 8'(CELLS);
    assign wr_left  = in_xfer && idx_ok && !i_in.operation;
    assign wr_right = in_xfer && idx_ok && i_in.operation;

    // ---------------------------------------------------------------
    // Sequencer: step counter, microcode word, loop counters
    // ---------------------------------------------------------------
    t_uc_addr          r_upc, n_upc;
    t_uc_word          uw;
    logic [KW-1:0]     r_k, r_i, r_j;
    logic [ADDR_W-1:0] r_e;
    logic              freeze;
    logic              adv;
    logic              cond_hit;
    logic              issue;

    assign uw         = uc_rom(r_upc);
    assign o_in_stall = (r_upc != UC_IDLE);
    assign freeze     = o_out_valid && i_out_stall;
    assign adv        = !freeze;
    assign issue      = uw.issue && adv;

    always_comb begin
        case (uw.cond)
            COND_ALWAYS: cond_hit = 1'b1;
            COND_K_PEN:  cond_hit = (r_k == KW'(DIM - 2));
            COND_E_LAST: cond_hit = (r_e == ADDR_W'(CELLS - 1));
            default:     cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (in_xfer && i_in.compute_after) begin
            n_upc = UC_MAC;
        end else if (adv) begin
            n_upc = cond_hit ? uw.taken : uw.other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UC_IDLE;
            r_k   <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_e   <= '0;
        end else begin
            r_upc <= n_upc;
            if (in_xfer) begin
                r_k <= '0;
                r_i <= '0;
                r_j <= '0;
                r_e <= '0;
            end else if (issue) begin
                if (uw.elem_adv) begin
                    r_k <= '0;
                    r_e <= r_e + 1'b1;
                    if (r_i == KW'(DIM - 1)) begin
                        r_i <= '0;
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // left[k*DIM+i], right[j*DIM+k]
    logic [ADDR_W-1:0] rd_left;
    logic [ADDR_W-1:0] rd_right;

    assign rd_left  = ADDR_W'(ADDR_W'(r_k) * ADDR_W'(DIM) + ADDR_W'(r_i));
    assign rd_right = ADDR_W'(ADDR_W'(r_j) * ADDR_W'(DIM) + ADDR_W'(r_k));

    // ---------------------------------------------------------------
    // Element memories, registered read
    // ---------------------------------------------------------------
    logic        [DATA_WIDTH-1:0] r_left_mem  [CELLS];
    logic        [DATA_WIDTH-1:0] r_right_mem [CELLS];
    logic signed [DATA_WIDTH-1:0] r_a;
    logic signed [DATA_WIDTH-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (wr_left) begin
            r_left_mem[wr_addr] <= i_in.element_value[DATA_WIDTH-1:0];
        end
        if (adv) begin
            r_a <= r_left_mem[rd_left];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_right) begin
            r_right_mem[wr_addr] <= i_in.element_value[DATA_WIDTH-1:0];
        end
        if (adv) begin
            r_b <= r_right_mem[rd_right];
        end
    end

    // ---------------------------------------------------------------
    // Pipe: read -> multiply -> accumulate -> shift/saturate
    // ---------------------------------------------------------------
    logic                            r_p1_v, r_p1_first, r_p1_last;
    logic [ADDR_W-1:0]               r_p1_e;
    logic                            r_p2_v, r_p2_first, r_p2_last;
    logic [ADDR_W-1:0]               r_p2_e;
    logic signed [2*DATA_WIDTH-1:0]  r_prod;
    logic                            r_p3_v;
    logic [ADDR_W-1:0]               r_p3_e;
    logic signed [ACC_W-1:0]         r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else if (adv) begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v && r_p2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_first <= (r_k == '0);
            r_p1_last  <= uw.last_k;
            r_p1_e     <= r_e;
            r_p2_first <= r_p1_first;
            r_p2_last  <= r_p1_last;
            r_p2_e     <= r_p1_e;
            r_prod     <= r_a * r_b;
            r_p3_e     <= r_p2_e;
            if (r_p2_v) begin
                r_acc <= r_p2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
            end
        end
    end

    // floor shift, then clamp to DATA_WIDTH signed
    logic signed [ACC_W-1:0]      shifted;
    logic [ACC_W-DATA_WIDTH:0]    top;
    logic [DATA_WIDTH-1:0]        sat;

    assign shifted = r_acc >>> FRAC;
    assign top     = shifted[ACC_W-1:DATA_WIDTH-1];

    always_comb begin
        if ((&top) || !(|top)) begin
            sat = shifted[DATA_WIDTH-1:0];
        end else if (top[ACC_W-DATA_WIDTH]) begin
            sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p3_v) begin
            o_out.result_index <= 4'(r_p3_e);
            o_out.result_value <= 32'(sat);
            o_out.result_last  <= (r_p3_e == ADDR_W'(CELLS - 1));
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_macl_k_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UC_MACL) |-> (r_k == KW'(DIM - 1)))
        else $error("closing step reached with k not at last term");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.compute_after) |=> (r_upc == UC_MAC && r_e == '0))
        else $error("multiply did not start from element zero");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.result_last) |-> (o_out.result_index == 4'(CELLS - 1)))
        else $error("last marker on wrong element");

    a_freeze_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (freeze && r_p3_v) |=> r_p3_v)
        else $error("finished sum lost during output stall");

endmodule

// ===== verif/matrix4_multiply_tb.sv =====
// matrix4_multiply_tb: self-checking testbench for the 4x4 fixed-point matrix multiplier.
// Depends on src/mm4_pkg.sv (transfer structs) and src/matrix4_multiply.sv (DUT).
`timescale 1ns / 100ps

module matrix4_multiply_tb;
    import mm4_pkg::*;

    // operand select carried by each input transfer
    localparam logic OP_LEFT  = 1'b0;
    localparam logic OP_RIGHT = 1'b1;

    localparam int CELLS    = 16;
    localparam int FRAC     = 16;
    localparam int IDLE_PCT = 11;

    // saturation bounds, held at accumulator width
    localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
    localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    matrix4_multiply DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Shadow copy of both operand stores, kept in step with accepted transfers.
    logic signed [31:0] left_el  [CELLS];
    logic signed [31:0] right_el [CELLS];

    t_in_item  pending_elements[$];   // element writes still to be offered
    t_out_item expected_products[$];  // product elements not yet seen on the output

    int  total_items;
    int  accepted_count;
    int  product_count;
    int  fault_count;
    bit  in_taken;      // last offered transfer went in at the previous rising edge
    bit  running;       // reset has been released
    int  hold_left;     // receiver hold-off, counted down in the stall process
    bit  hold_done;

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Generous ceiling: even if every transfer asked for a multiply, and every
    // product sat out receiver stalls, the run stays well inside this.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus values
    // ------------------------------------------------------------------
    // Corner values of Q16.16: both bounds, zero, the smallest steps either
    // way, plus and minus one, and one half.
    function automatic logic signed [31:0] edge_value(input int sel);
        case (sel % 8)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'sh0000_0001;
            4:       return 32'shFFFF_FFFF;
            5:       return 32'sh0001_0000;
            6:       return 32'shFFFF_0000;
            default: return 32'sh0000_8000;
        endcase
    endfunction

    // Mostly moderate magnitudes so that sums stay in range and rounding is
    // exercised; the rest full-range or corners, which mostly saturate.
    function automatic logic signed [31:0] pick_value();
        int r;
        logic [31:0] raw;
        r   = $urandom_range(99);
        raw = $urandom;
        if (r < 60) begin
            return {{11{raw[31]}}, raw[20:0]};
        end else if (r < 80) begin
            return raw;
        end else begin
            return edge_value($urandom_range(7));
        end
    endfunction

    task automatic queue_element(input logic op, input int idx,
                                 input logic signed [31:0] value, input logic go);
        t_in_item item;
        item.operation     = op;
        item.element_index = idx[3:0];
        item.element_value = value;
        item.compute_after = go;
        pending_elements.push_back(item);
    endtask

    // ------------------------------------------------------------------
    // Predictor: store the element, then on request form all sixteen dot
    // products at full precision, floor-shift by FRAC and clamp.
    // ------------------------------------------------------------------
    task automatic store_and_multiply(input t_in_item item);
        logic signed [65:0] dot;
        logic signed [65:0] scaled;
        t_out_item prod;
        if (item.operation == OP_LEFT) begin
            left_el[item.element_index] = item.element_value;
        end else begin
            right_el[item.element_index] = item.element_value;
        end
        if (item.compute_after) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    dot = '0;
                    for (int k = 0; k < 4; k++) begin
                        dot = dot + left_el[k*4 + i] * right_el[j*4 + k];
                    end
                    scaled = dot >>> FRAC;   // arithmetic shift: rounds towards minus infinity
                    if (scaled > Q_MAX) begin
                        scaled = Q_MAX;
                    end else if (scaled < Q_MIN) begin
                        scaled = Q_MIN;
                    end
                    prod.result_index = 4'(j*4 + i);
                    prod.result_value = scaled[31:0];
                    prod.result_last  = (j*4 + i == CELLS - 1);
                    expected_products.push_back(prod);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. Output is checked
    // before the input transfer of the same edge is predicted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        running <= i_rst_n;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                product_count++;
                if (expected_products.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected product: index %0d value %08h last %0b",
                                 o_out.result_index, o_out.result_value, o_out.result_last);
                    end
                end else begin
                    want = expected_products.pop_front();
                    if (o_out.result_index !== want.result_index ||
                        o_out.result_value !== want.result_value ||
                        o_out.result_last  !== want.result_last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"mismatch: exp index %0d value %08h last %0b, ",
                                      "got index %0d value %08h last %0b"},
                                     want.result_index, want.result_value,
                                     want.result_last, o_out.result_index,
                                     o_out.result_value, o_out.result_last);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                store_and_multiply(i_in);
                accepted_count++;
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the next queued element at the falling edge. A transfer
    // on offer is held, unchanged, until it is taken. Idle cycles are random
    // apart from a stretch in the middle of the run.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit idle;
        idle = (accepted_count < 180 || accepted_count >= 260) &&
               ($urandom_range(99) < IDLE_PCT);
        if (running && (!i_in_valid || in_taken)) begin
            if (pending_elements.size() != 0 && !idle) begin
                i_in       <= pending_elements.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, a quiet stretch, and one long hold-off once the
    // output is busy, so the pipe freezes and the input backs up behind it.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && product_count >= 100) begin
            i_out_stall <= 1'b1;
            hold_left   <= 400;
            hold_done   <= 1'b1;
        end else if (product_count >= 400 && product_count < 600) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int kind;
        int burst;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_stall    = 1'b0;
        in_taken       = 1'b0;
        running        = 1'b0;
        hold_left      = 0;
        hold_done      = 1'b0;
        accepted_count = 0;
        product_count  = 0;
        fault_count    = 0;

        // Every entry of both stores is written before the first multiply.
        // Left: identity with a raw -1 scattered off the diagonal, so small
        // negative terms test floor rounding. Right: the corner values.
        for (int n = 0; n < CELLS; n++) begin
            queue_element(OP_LEFT, n,
                          (n % 5 == 0) ? edge_value(5) : ((n % 2) ? edge_value(4) : edge_value(2)),
                          1'b0);
        end
        for (int n = 0; n < CELLS; n++) begin
            queue_element(OP_RIGHT, n, edge_value(n), n == CELLS - 1);
        end
        // positive overflow: two max-by-max terms in product element 0
        queue_element(OP_LEFT,  0, edge_value(0), 1'b0);
        queue_element(OP_LEFT,  4, edge_value(0), 1'b0);
        queue_element(OP_RIGHT, 0, edge_value(0), 1'b0);
        queue_element(OP_RIGHT, 1, edge_value(0), 1'b1);
        // negative overflow: max-by-min terms in product element 4
        queue_element(OP_RIGHT, 4, edge_value(1), 1'b0);
        queue_element(OP_RIGHT, 5, edge_value(1), 1'b1);
        // min-by-min, the largest single product
        queue_element(OP_LEFT,  0, edge_value(1), 1'b0);
        queue_element(OP_RIGHT, 0, edge_value(1), 1'b1);

        // Random part: mostly runs of writes closed by a multiply request,
        // some lone multiplies and some writes with no multiply at all.
        while (pending_elements.size() < 330) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                burst = $urandom_range(10, 1);
                for (int n = 0; n < burst; n++) begin
                    queue_element(1'($urandom_range(1)), $urandom_range(15), pick_value(),
                                  n == burst - 1);
                end
            end else if (kind < 90) begin
                queue_element(1'($urandom_range(1)), $urandom_range(15), pick_value(), 1'b1);
            end else begin
                burst = $urandom_range(4, 1);
                for (int n = 0; n < burst; n++) begin
                    queue_element(1'($urandom_range(1)), $urandom_range(15), pick_value(),
                                  1'b0);
                end
            end
        end
        total_items = pending_elements.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items) @(posedge i_clk);
        while (expected_products.size() != 0) @(posedge i_clk);
        // room for a stray extra product to show up
        repeat (100) @(posedge i_clk);

        if (fault_count == 0 && expected_products.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
